// ===== src/sled_pkg.sv =====
// Shared types and constants of the sound level event detector.
package sled_pkg;

	localparam int unsigned LVL_W  = 25;
	localparam int unsigned SUM_W  = 24;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned COOL_W = 16;
	localparam int unsigned EV_W   = 3;
	localparam int unsigned IDX_W  = 3;

	localparam logic [TIME_W-1:0] TRAIN_MS = 32'd1600;
	localparam logic [TIME_W-1:0] QUIET_MS = 32'd45000;
	localparam logic [COOL_W-1:0] COOL_DEF = 16'd1500;
	localparam logic [COOL_W-1:0] COOL_MIN = 16'd250;

	localparam logic [IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPIKE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CLAP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_QUIET  = 3'd3;
	localparam logic [IDX_W-1:0] REG_COOL   = 3'd4;

	localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EV_W-1:0] EV_SPIKE  = 3'd1;
	localparam logic [EV_W-1:0] EV_CLAP   = 3'd2;
	localparam logic [EV_W-1:0] EV_QUIET  = 3'd3;
	localparam logic [EV_W-1:0] EV_LOUD   = 3'd4;
	localparam logic [EV_W-1:0] EV_REPEAT = 3'd5;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_DIV,
		ST_AVG,
		ST_AMB,
		ST_DEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start_div;
		logic div_step;
		logic do_avg;
		logic do_amb;
		logic do_dec;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic div_done;
	} sts_t;

endpackage

// ===== src/sled_ctrl.sv =====
// Controller state machine sequencing accumulation, division and evaluation.
module sled_ctrl
	import sled_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic res_load
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = 1'b1;
				if (in_fire && sts.frame_end) begin
					cmd.start_div = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.do_avg = 1'b1;
				state_d = ST_AMB;
			end
			ST_AMB: begin
				cmd.do_amb = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.do_dec = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

endmodule

// ===== src/sled_datapath.sv =====
// Datapath: frame accumulator, serial divider, averages and event decision.
module sled_datapath
	import sled_pkg::*;
#(
	parameter int unsigned FRAME_MAX    = 64,
	parameter int unsigned SAMPLE_SHIFT = 14,
	parameter int unsigned FRAC_BITS    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [31:0]       sample,
	input  logic              last_in_frame,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [LVL_W-1:0]  cfg_data,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [LVL_W-1:0]  level,
	output logic [LVL_W-1:0]  ambient,
	output logic [LVL_W-1:0]  peak,
	output logic [EV_W-1:0]   event_res,
	output logic              spike_now,
	output logic              clap_now,
	output logic              room_quiet
);

	localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);
	localparam int unsigned NUM_W = SUM_W + FRAC_BITS;
	localparam int unsigned DIT_W = $clog2(NUM_W + 1);
	localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRAC_BITS;
	localparam logic [LVL_W-1:0] SPIKE_DEF = LVL_W'(200) << FRAC_BITS;
	localparam logic [LVL_W-1:0] CLAP_DEF  = LVL_W'(800) << FRAC_BITS;
	localparam logic [LVL_W-1:0] QUIET_DEF = LVL_W'(40) << FRAC_BITS;
	localparam logic [32:0] RND = (33'd1 << SAMPLE_SHIFT) - 33'd1;

	logic              en_q;
	logic [LVL_W-1:0]  spk_thr_q, clp_thr_q, qui_thr_q;
	logic [COOL_W-1:0] cool_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			spk_thr_q <= SPIKE_DEF;
			clp_thr_q <= CLAP_DEF;
			qui_thr_q <= QUIET_DEF;
			cool_q <= COOL_DEF;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_SPIKE:  spk_thr_q <= (cfg_data > ONE) ? cfg_data : SPIKE_DEF;
				REG_CLAP:   clp_thr_q <= (cfg_data > ONE) ? cfg_data : CLAP_DEF;
				REG_QUIET:  qui_thr_q <= (cfg_data > ONE) ? cfg_data : QUIET_DEF;
				REG_COOL:   cool_q <= (cfg_data[COOL_W-1:0] >= COOL_MIN) ?
					cfg_data[COOL_W-1:0] : COOL_DEF;
				default: ;
			endcase
		end
	end

	// Magnitude of the shifted sample; negative words round up.
	logic [32:0] mag_abs;
	logic [32:0] mag;
	logic [SUM_W:0] sum_add;
	logic [SUM_W-1:0] sum_sat;
	logic [CNT_W-1:0] cnt_inc;
	logic frame_end, div_done;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		mag_abs = sample[31] ? (33'h100000000 - {1'b0, sample}) : {1'b0, sample};
		mag = sample[31] ? ((mag_abs + RND) >> SAMPLE_SHIFT) : (mag_abs >> SAMPLE_SHIFT);
		if (mag > 33'((1 << SUM_W) - 1)) begin
			sum_add = {1'b1, {SUM_W{1'b0}}};
		end else begin
			sum_add = {1'b0, sum_q} + {1'b0, mag[SUM_W-1:0]};
		end
		sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		cnt_inc = cnt_q + CNT_W'(1);
		frame_end = last_in_frame || (cnt_inc >= CNT_W'(FRAME_MAX));
	end

	// Restoring divider, one quotient bit a cycle.
	logic [NUM_W-1:0] num_q, quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] div_q;
	logic [DIT_W-1:0] dit_q;
	logic [CNT_W:0]   rem_sh;

	always_comb begin
		rem_sh = {rem_q[CNT_W-1:0], num_q[NUM_W-1]};
		div_done = (dit_q == DIT_W'(1));
	end

	assign sts = {frame_end, div_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			dit_q <= '0;
		end else if (in_fire) begin
			if (cmd.start_div) begin
				sum_q <= '0;
				cnt_q <= '0;
				dit_q <= DIT_W'(NUM_W);
			end else begin
				sum_q <= sum_sat;
				cnt_q <= cnt_inc;
			end
		end else if (cmd.div_step) begin
			dit_q <= dit_q - DIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && cmd.start_div) begin
			num_q <= {sum_sat, FRAC_BITS'(0)};
			div_q <= cnt_inc;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, div_q}) begin
				rem_q <= rem_sh - {1'b0, div_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// Averages; constant divisions become reciprocal multiplies.
	// The level is updated first, ambient and peak in the next cycle from it.
	logic [LVL_W-1:0] mean;
	logic [LVL_W-1:0] lev_q, amb_q, pk_q;
	logic [LVL_W+3:0] lev_num;
	logic [LVL_W+6:0] amb_num;
	logic [LVL_W+7:0] pk_num;
	logic [LVL_W-1:0] lev_new, amb_new, pk_new;

	function automatic logic [LVL_W-1:0] div_const(input logic [39:0] n,
		input logic [39:0] d, input logic [39:0] recip, input int unsigned sh);
		logic [79:0] p;
		logic [39:0] q, r;
		begin
			p = n * recip;
			q = 40'(p >> sh);
			r = n - q * d;
			if (r >= d) q = q + 40'd1;
			div_const = q[LVL_W-1:0];
		end
	endfunction

	always_comb begin
		mean = (quo_q > NUM_W'({LVL_W{1'b1}})) ? {LVL_W{1'b1}} : quo_q[LVL_W-1:0];
		lev_num = 29'(7 * lev_q) + 29'(3 * mean);
		lev_new = div_const(40'(lev_num), 40'd10, 40'd3435973837, 35);
		amb_num = 32'(49 * amb_q) + 32'(lev_q);
		amb_new = (amb_q <= ONE) ? lev_q :
			div_const(40'(amb_num), 40'd50, 40'd2748779069, 37);
		pk_num = 33'(197 * pk_q);
		pk_new = (lev_q > pk_q) ? lev_q :
			div_const(40'(pk_num), 40'd200, 40'd2748779069, 39);
	end

	// Event decision runs in the cycle after the ambient and peak update.
	logic [LVL_W+2:0] diff4, spk3;
	logic             spike, clap, loud, quiet, ok;
	logic [TIME_W-1:0] dt_ev, dt_sp, dt_qu;

	logic qv_q, evv_q, spv_q;
	logic [TIME_W-1:0] qs_q, evt_q, spt_q, now_q;
	logic [7:0] run_q;
	logic [EV_W-1:0] ev_q;

	always_comb begin
		spike = (lev_q > amb_q) && ((lev_q - amb_q) > spk_thr_q);
		diff4 = {lev_q - amb_q, 2'b00};
		spk3 = 28'(3 * spk_thr_q);
		clap = (lev_q > clp_thr_q) && (lev_q > amb_q) && (diff4 > spk3);
		loud = 28'(5 * amb_q) > 28'(4 * spk_thr_q);
		quiet = (amb_q < qui_thr_q) && (30'(20 * lev_q) < 30'(27 * qui_thr_q));
		dt_ev = now_q - evt_q;
		dt_sp = now_q - spt_q;
		dt_qu = now_q - qs_q;
		ok = en_q && (!evv_q || dt_ev >= TIME_W'(cool_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lev_q <= '0;
			amb_q <= '0;
			pk_q <= '0;
			qv_q <= 1'b0;
			evv_q <= 1'b0;
			spv_q <= 1'b0;
			qs_q <= '0;
			evt_q <= '0;
			spt_q <= '0;
			run_q <= '0;
		end else if (cmd.do_avg) begin
			lev_q <= lev_new;
		end else if (cmd.do_amb) begin
			amb_q <= amb_new;
			pk_q <= pk_new;
		end else if (cmd.do_dec) begin
			qv_q <= quiet;
			if (quiet && !qv_q) qs_q <= now_q;
			if (ok) begin
				if (clap) begin
					spv_q <= 1'b1;
					spt_q <= now_q;
					run_q <= '0;
				end else if (spike) begin
					if (spv_q && dt_sp < TRAIN_MS) begin
						if (run_q != 8'hFF) run_q <= run_q + 8'd1;
					end else begin
						run_q <= 8'd1;
					end
					spv_q <= 1'b1;
					spt_q <= now_q;
				end else if (!loud && qv_q && quiet && dt_qu > QUIET_MS) begin
					qs_q <= now_q;
				end
				if (clap || spike || loud || (qv_q && quiet && dt_qu > QUIET_MS)) begin
					evv_q <= 1'b1;
					evt_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) now_q <= now_ms;
		if (cmd.do_dec) begin
			ev_q <= EV_NONE;
			if (ok) begin
				if (clap) ev_q <= EV_CLAP;
				else if (spike) ev_q <= (spv_q && dt_sp < TRAIN_MS && run_q >= 8'd2) ?
					EV_REPEAT : EV_SPIKE;
				else if (loud) ev_q <= EV_LOUD;
				else if (qv_q && quiet && dt_qu > QUIET_MS) ev_q <= EV_QUIET;
			end
		end
	end

	assign level = lev_q;
	assign ambient = amb_q;
	assign peak = pk_q;
	assign event_res = ev_q;
	assign spike_now = spike;
	assign clap_now = lev_q > clp_thr_q;
	assign room_quiet = amb_q < qui_thr_q;

endmodule

// ===== src/sound_level_event_detector_top.sv =====
// Top level of the sound level event detector.
//  channel  dir  handshake          payload
//  s_axis   in   tvalid/tready      tdata sample, now_ms; tlast last_in_frame
//  m_axis   out  tvalid/tready      tdata level, ambient, peak, event_res, flags
//  cfg      in   cfg_we             cfg_idx, cfg_data
// A sample is taken every cycle while a frame is being accumulated.
// After the closing sample tready stays low while the divider steps, the level and then
// ambient and peak are averaged, the event is decided and the result is loaded.
// The load waits while the result register still holds an unread result.
// The result register holds the last result while the next frame accumulates.
// Reset clears averages, timers and event state and sets config registers to defaults.
module sound_level_event_detector_top
	import sled_pkg::*;
#(
	parameter int unsigned FRAME_MAX    = 64,
	parameter int unsigned SAMPLE_SHIFT = 14,
	parameter int unsigned FRAC_BITS    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // sample, now_ms
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [87:0]       m_axis_tdata,  // level, ambient, peak, event_res, spike_now,
	                                         // clap_now, room_quiet
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [LVL_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready, res_load, in_fire, out_free;
	logic [LVL_W-1:0] level, ambient, peak;
	logic [EV_W-1:0] event_res;
	logic spike_now, clap_now, room_quiet;
	logic [80:0] res_q;
	logic vld_q;

	assign in_fire = s_axis_tvalid && in_ready;
	assign out_free = !vld_q || m_axis_tready;
	assign s_axis_tready = in_ready;

	sled_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .in_ready(in_ready), .res_load(res_load)
	);

	sled_datapath #(
		.FRAME_MAX(FRAME_MAX), .SAMPLE_SHIFT(SAMPLE_SHIFT), .FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.sample(s_axis_tdata[31:0]), .last_in_frame(s_axis_tlast),
		.now_ms(s_axis_tdata[63:32]), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .cmd(cmd), .sts(sts), .level(level),
		.ambient(ambient), .peak(peak), .event_res(event_res),
		.spike_now(spike_now), .clap_now(clap_now), .room_quiet(room_quiet)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_load) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= {room_quiet, clap_now, spike_now, event_res, peak, ambient, level};
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {7'b0, res_q};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sound level event detector top level.
module tb_top;
	import sled_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_MAX  = 64;
	localparam int unsigned SHIFT      = 14;
	localparam int unsigned FRAC       = 8;
	localparam int unsigned WATCH_MAX  = 6000;
	localparam int unsigned DRAIN_WAIT = 80;
	localparam logic [LVL_W-1:0] SPIKE_RST = 25'd51200;
	localparam logic [LVL_W-1:0] CLAP_RST  = 25'd204800;
	localparam logic [LVL_W-1:0] QUIET_RST = 25'd10240;
	localparam logic [LVL_W-1:0] LVL_MAX   = 25'h1FFFFFF;

	typedef struct {
		logic [31:0] word;
		logic        last;
		logic [31:0] now_ms;
	} mic_req_t;

	typedef struct {
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] ambient;
		logic [LVL_W-1:0] peak;
		logic [EV_W-1:0]  ev;
		logic             spike;
		logic             clap;
		logic             quiet;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [LVL_W-1:0] cfg_data = '0;

	sound_level_event_detector_top i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Predictor state and register copies.
	logic             en_r;
	logic [LVL_W-1:0] spike_thr, clap_thr, quiet_thr;
	logic [COOL_W-1:0] cool_r;
	logic [SUM_W-1:0] acc_sum;
	int unsigned      acc_cnt;
	logic [LVL_W-1:0] lvl_s, amb_s, pk_s;
	logic             quiet_on, ev_seen, spk_seen;
	logic [31:0]      quiet_t0, ev_t, spk_t;
	int unsigned      spk_run;

	mic_req_t mic_q[$];
	status_t  status_q[$];
	int unsigned n_err = 0;
	int unsigned watch = 0;
	int unsigned n_items = 0;
	logic [31:0] clock_ms;

	function automatic longint unsigned mic_mag(logic [31:0] w);
		longint unsigned a;
		if (w[31]) begin
			a = 64'h1_0000_0000 - w;
			return (a + (1 << SHIFT) - 1) >> SHIFT;
		end
		return w >> SHIFT;
	endfunction

	function automatic void predict_status(mic_req_t r);
		longint unsigned s, mean, lev, amb, pk;
		longint d;
		logic spike, clap, loud, quiet;
		logic [EV_W-1:0] ev;
		status_t st;
		s = acc_sum + mic_mag(r.word);
		acc_sum = (s > 64'hFF_FFFF) ? 24'hFF_FFFF : s[SUM_W-1:0];
		acc_cnt++;
		if (!r.last && acc_cnt < FRAME_MAX)
			return;
		mean = (longint'(acc_sum) << FRAC) / acc_cnt;
		if (mean > LVL_MAX) mean = LVL_MAX;
		acc_sum = '0;
		acc_cnt = 0;
		lev = (7 * longint'(lvl_s) + 3 * mean) / 10;
		if (amb_s <= (1 << FRAC))
			amb = lev;
		else
			amb = (49 * longint'(amb_s) + lev) / 50;
		pk = (lev > pk_s) ? lev : (longint'(pk_s) * 197) / 200;
		lvl_s = lev[LVL_W-1:0];
		amb_s = amb[LVL_W-1:0];
		pk_s = pk[LVL_W-1:0];
		d = longint'(lvl_s) - longint'(amb_s);
		spike = d > longint'(spike_thr);
		clap = (lvl_s > clap_thr) && (4 * d > 3 * longint'(spike_thr));
		loud = 5 * longint'(amb_s) > 4 * longint'(spike_thr);
		quiet = (amb_s < quiet_thr) && (20 * longint'(lvl_s) < 27 * longint'(quiet_thr));
		ev = EV_NONE;
		if (quiet) begin
			if (!quiet_on) begin
				quiet_on = 1'b1;
				quiet_t0 = r.now_ms;
			end
		end else begin
			quiet_on = 1'b0;
		end
		if (en_r && (!ev_seen || (r.now_ms - ev_t) >= cool_r)) begin
			if (clap) begin
				ev = EV_CLAP;
				spk_seen = 1'b1;
				spk_t = r.now_ms;
				spk_run = 0;
			end else if (spike) begin
				if (spk_seen && (r.now_ms - spk_t) < TRAIN_MS) begin
					if (spk_run < 255) spk_run++;
				end else begin
					spk_run = 1;
				end
				spk_seen = 1'b1;
				spk_t = r.now_ms;
				ev = (spk_run >= 3) ? EV_REPEAT : EV_SPIKE;
			end else if (loud) begin
				ev = EV_LOUD;
			end else if (quiet_on && (r.now_ms - quiet_t0) > QUIET_MS) begin
				ev = EV_QUIET;
				quiet_t0 = r.now_ms;
			end
			if (ev != EV_NONE) begin
				ev_seen = 1'b1;
				ev_t = r.now_ms;
			end
		end
		st.level = lvl_s;
		st.ambient = amb_s;
		st.peak = pk_s;
		st.ev = ev;
		st.spike = spike;
		st.clap = lvl_s > clap_thr;
		st.quiet = amb_s < quiet_thr;
		status_q.push_back(st);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: feeds the queued sample requests.
	int unsigned drv_gap = 0;
	logic drv_busy = 1'b0;
	always @(posedge clk) begin
		mic_req_t r;
		logic nv;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				r.word = s_axis_tdata[31:0];
				r.now_ms = s_axis_tdata[63:32];
				r.last = s_axis_tlast;
				predict_status(r);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				nv = 1'b0;
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (mic_q.size() > 0) begin
					r = mic_q.pop_front();
					nv = 1'b1;
					s_axis_tdata <= {r.now_ms, r.word};
					s_axis_tlast <= r.last;
					drv_gap = pick_gap();
				end
				s_axis_tvalid <= nv;
				drv_busy = nv;
			end
		end
	end

	// Monitor: checks each status result and applies receiver stalls.
	int unsigned stall = 0;
	always @(posedge clk) begin
		status_t e;
		status_t g;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				g.level = m_axis_tdata[24:0];
				g.ambient = m_axis_tdata[49:25];
				g.peak = m_axis_tdata[74:50];
				g.ev = m_axis_tdata[77:75];
				g.spike = m_axis_tdata[78];
				g.clap = m_axis_tdata[79];
				g.quiet = m_axis_tdata[80];
				if (status_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected status result %h", m_axis_tdata);
				end else begin
					e = status_q.pop_front();
					if (g.level !== e.level || g.ambient !== e.ambient ||
					    g.peak !== e.peak || g.ev !== e.ev ||
					    g.spike !== e.spike || g.clap !== e.clap ||
					    g.quiet !== e.quiet) begin
						n_err++;
						if (n_err <= 10) begin
							$display("status mismatch: exp lvl %0d amb %0d pk %0d ev %0d",
								e.level, e.ambient, e.peak, e.ev,
								" sp %0b cl %0b rq %0b", e.spike, e.clap, e.quiet);
							$display("                 got lvl %0d amb %0d pk %0d ev %0d",
								g.level, g.ambient, g.peak, g.ev,
								" sp %0b cl %0b rq %0b", g.spike, g.clap, g.quiet);
						end
					end
				end
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				stall = pick_gap();
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted request.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			watch = 0;
		else
			watch++;
		if (watch >= WATCH_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE: en_r = val[0];
			REG_SPIKE:  spike_thr = (val > (1 << FRAC)) ? val : SPIKE_RST;
			REG_CLAP:   clap_thr = (val > (1 << FRAC)) ? val : CLAP_RST;
			REG_QUIET:  quiet_thr = (val > (1 << FRAC)) ? val : QUIET_RST;
			REG_COOL:   cool_r = (val[15:0] >= COOL_MIN) ? val[15:0] : COOL_DEF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (mic_q.size() > 0 || drv_busy || s_axis_tvalid || status_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] mic_word(int unsigned kind);
		logic [31:0] m;
		logic [31:0] w;
		case (kind)
			0: m = $urandom_range(0, 30);
			1: m = $urandom_range(0, 2000);
			2: m = $urandom_range(2000, 131071);
			default: return $urandom;
		endcase
		w = (m << SHIFT) | ($urandom & 32'h3FFF);
		if ($urandom_range(0, 1)) w = -w;
		return w;
	endfunction

	task automatic add_frame(int unsigned n, int unsigned kind, logic force_end);
		mic_req_t r;
		for (int unsigned i = 0; i < n; i++) begin
			r.word = mic_word(kind);
			r.last = force_end ? (i == n - 1) : ($urandom_range(0, 15) == 0);
			r.now_ms = clock_ms;
			mic_q.push_back(r);
			n_items++;
			if ($urandom_range(0, 3) == 0) clock_ms += 1;
		end
		case ($urandom_range(0, 19))
			0: clock_ms += $urandom_range(45000, 60000);
			1, 2: clock_ms += $urandom_range(1500, 5000);
			default: clock_ms += $urandom_range(0, 800);
		endcase
	endtask

	task automatic random_phase(int unsigned count);
		int unsigned goal;
		int unsigned p;
		goal = n_items + count;
		while (n_items < goal) begin
			p = $urandom_range(0, 99);
			if (p < 85)
				add_frame($urandom_range(1, 8), $urandom_range(0, 3), 1'b1);
			else if (p < 95)
				add_frame($urandom_range(1, 12), $urandom_range(0, 3), 1'b0);
			else
				add_frame($urandom_range(60, 70), $urandom_range(0, 3), 1'b1);
		end
	endtask

	initial begin
		mic_req_t r;
		en_r = 1'b1;
		spike_thr = SPIKE_RST;
		clap_thr = CLAP_RST;
		quiet_thr = QUIET_RST;
		cool_r = COOL_DEF;
		acc_sum = '0;
		acc_cnt = 0;
		lvl_s = '0;
		amb_s = '0;
		pk_s = '0;
		quiet_on = 1'b0;
		ev_seen = 1'b0;
		spk_seen = 1'b0;
		quiet_t0 = '0;
		ev_t = '0;
		spk_t = '0;
		spk_run = 0;
		clock_ms = 32'hFFFF_0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme words, odd negatives, a frame closed by length.
		begin
			logic [31:0] words[8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
				32'h0, 32'h1, 32'hFFFF_C001, 32'hFFFF_C000, 32'h5555_AAAA};
			foreach (words[i]) begin
				r.word = words[i];
				r.last = (i % 2 == 1);
				r.now_ms = clock_ms;
				mic_q.push_back(r);
				clock_ms += 700;
			end
		end
		add_frame(64, 2, 1'b0);
		add_frame(2, 2, 1'b1);
		add_frame(3, 0, 1'b1);
		wait_idle();

		// Walk the registers through extremes, invalid writes and normal settings.
		write_reg(REG_COOL, 16'd250);
		write_reg(REG_SPIKE, 25'd257);
		write_reg(REG_CLAP, 25'd257);
		write_reg(3'd5, 25'd1234);
		random_phase(200);
		wait_idle();
		write_reg(REG_SPIKE, LVL_MAX);
		write_reg(REG_CLAP, LVL_MAX);
		write_reg(REG_QUIET, LVL_MAX);
		write_reg(REG_COOL, 16'd65535);
		random_phase(200);
		wait_idle();
		write_reg(REG_SPIKE, 25'd256);
		write_reg(REG_CLAP, 25'd0);
		write_reg(REG_QUIET, 25'd257);
		write_reg(REG_COOL, 16'd249);
		write_reg(3'd7, 25'd0);
		random_phase(200);
		wait_idle();
		write_reg(REG_ENABLE, 1'b0);
		write_reg(REG_QUIET, 25'd100000);
		random_phase(150);
		wait_idle();
		write_reg(REG_ENABLE, 1'b1);
		write_reg(REG_COOL, 16'd0);
		write_reg(REG_SPIKE, 25'd20000);
		write_reg(REG_QUIET, 25'd256);
		random_phase(250);
		wait_idle();
		write_reg(REG_COOL, 16'd300);
		write_reg(REG_SPIKE, 25'($urandom_range(300, 200000)));
		write_reg(REG_CLAP, 25'($urandom_range(300, 2000000)));
		write_reg(REG_QUIET, 25'($urandom_range(300, 50000)));
		random_phase(300);
		wait_idle();

		if (n_err == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
